// ===== rtl/core/debug_step_run_controller_assert.svh =====
// Assertion macros used by the top RTL file of the run-control block.
`ifndef DEBUG_STEP_RUN_CONTROLLER_ASSERT_SVH
`define DEBUG_STEP_RUN_CONTROLLER_ASSERT_SVH

// Check on every rising edge outside reset.
`define DSRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on every rising edge, reset included.
`define DSRC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/dsrc_pkg.sv =====
`default_nettype none
package dsrc_pkg;

  // Event kinds carried in tuser
  localparam logic [1:0] OP_ARM    = 2'd0;
  localparam logic [1:0] OP_TRAP   = 2'd1;
  localparam logic [1:0] OP_RESUME = 2'd2;

  // Register indexes of the configuration port
  localparam logic REG_STEP_MODE  = 1'b0;
  localparam logic REG_STEP_COUNT = 1'b1;

  // Programmed step modes
  localparam logic [2:0] SMODE_COUNT    = 3'd0;
  localparam logic [2:0] SMODE_RETURN   = 3'd1;
  localparam logic [2:0] SMODE_CALLT    = 3'd2;
  localparam logic [2:0] SMODE_CONTINUE = 3'd3;
  localparam logic [2:0] SMODE_CONT_CNT = 3'd4;

  // Internal run modes
  localparam logic [2:0] MODE_NONE      = 3'd0;
  localparam logic [2:0] MODE_ONCE      = 3'd1;
  localparam logic [2:0] MODE_RETURN    = 3'd2;
  localparam logic [2:0] MODE_CALLT     = 3'd3;
  localparam logic [2:0] MODE_CONTINUE  = 3'd4;
  localparam logic [2:0] MODE_INVISIBLE = 3'd5;
  localparam logic [2:0] MODE_COUNT     = 3'd6;

  localparam logic [2:0]  STEP_MODE_RST  = SMODE_CONTINUE;
  localparam logic [30:0] STEP_COUNT_RST = 31'd1;
  localparam logic [15:0] LEVEL_MAX      = 16'hFFFF;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 120;

  typedef struct packed {
    logic [1:0] op;
    logic       trap_is_breakpoint;
    logic       bkpt_hit;
    logic       bkpt_fires;
    logic       watch_hit;
    logic       is_call;
    logic       is_return;
    logic       is_trap_return;
    logic       is_load;
    logic       is_store;
  } dsrc_item_t;

  typedef struct packed {
    logic [2:0]  run_mode;
    logic [31:0] steps_left;
    logic [15:0] call_level;
    logic [31:0] inst_total;
    logic [31:0] load_total;
    logic [31:0] store_total;
  } dsrc_state_t;

  typedef struct packed {
    logic stop;
    logic report_breakpoint;
    logic advance_pc;
    logic single_step;
    logic arm_breakpoints;
  } dsrc_flags_t;

  function automatic logic [2:0] map_step_mode(input logic [2:0] smode);
    logic [2:0] m;
    case (smode)
      SMODE_COUNT:    m = MODE_ONCE;
      SMODE_RETURN:   m = MODE_RETURN;
      SMODE_CALLT:    m = MODE_CALLT;
      SMODE_CONTINUE: m = MODE_CONTINUE;
      SMODE_CONT_CNT: m = MODE_COUNT;
      default:        m = MODE_NONE;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/dsrc_eval.sv =====
`default_nettype none
module dsrc_eval
  import dsrc_pkg::*;
(
  input  dsrc_item_t  item,
  input  dsrc_state_t cur,
  input  logic [2:0]  step_mode,
  input  logic [30:0] step_budget,
  output dsrc_state_t nxt,
  output dsrc_flags_t flags
);

  logic [31:0] steps_dec;
  logic [15:0] level_dec;
  logic        go_on;

  assign steps_dec = cur.steps_left - 32'd1;
  assign level_dec = (cur.call_level != 16'd0) ? cur.call_level - 16'd1 : cur.call_level;

  always_comb begin
    nxt   = cur;
    flags = '0;
    go_on = 1'b0;
    case (item.op)
      OP_ARM: begin
        if (step_mode inside {[SMODE_COUNT:SMODE_CONT_CNT]}) begin
          nxt.run_mode    = map_step_mode(step_mode);
          nxt.steps_left  = {1'b0, step_budget};
          nxt.call_level  = 16'd1;
          nxt.inst_total  = '0;
          nxt.load_total  = '0;
          nxt.store_total = '0;
        end
      end
      OP_TRAP: begin
        if (item.bkpt_hit && item.bkpt_fires) begin
          flags.stop              = 1'b1;
          flags.report_breakpoint = 1'b1;
        end else begin
          flags.advance_pc = !item.bkpt_hit && item.trap_is_breakpoint;
          flags.stop       = 1'b1;
          case (cur.run_mode)
            MODE_INVISIBLE: begin
              nxt.run_mode = MODE_CONTINUE;
              flags.stop   = 1'b0;
            end
            MODE_COUNT: flags.stop = 1'b0;
            MODE_ONCE: begin
              nxt.steps_left = steps_dec;
              if (steps_dec != 32'd0 && !steps_dec[31]) flags.stop = 1'b0;
            end
            MODE_RETURN: begin
              if (item.is_trap_return) begin
                go_on = 1'b0;
              end else if (!item.is_return) begin
                go_on = 1'b1;
              end else begin
                nxt.call_level = level_dec;
                go_on          = (level_dec != 16'd0);
              end
              if (go_on) begin
                flags.stop = 1'b0;
                if (item.is_call && nxt.call_level != LEVEL_MAX)
                  nxt.call_level = nxt.call_level + 16'd1;
              end
            end
            MODE_CALLT: begin
              if (!item.is_call && !item.is_return && !item.is_trap_return)
                flags.stop = 1'b0;
            end
            default: ;
          endcase
          if (flags.stop) nxt.run_mode = MODE_NONE;
        end
      end
      OP_RESUME: begin
        if (cur.run_mode inside {MODE_COUNT, MODE_RETURN, MODE_CALLT}) begin
          nxt.inst_total  = cur.inst_total + 32'd1;
          nxt.load_total  = cur.load_total + {31'd0, item.is_load};
          nxt.store_total = cur.store_total + {31'd0, item.is_store};
        end
        if (cur.run_mode == MODE_CONTINUE) begin
          if (item.watch_hit || item.bkpt_hit) begin
            nxt.run_mode      = MODE_INVISIBLE;
            flags.single_step = 1'b1;
          end else begin
            flags.arm_breakpoints = 1'b1;
          end
        end else begin
          flags.single_step = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/dsrc_state_regs.sv =====
`default_nettype none
module dsrc_state_regs
  import dsrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        commit,
  input  dsrc_state_t state_nxt,
  output dsrc_state_t state_r
);

  // Run state moves only when an event leaves the stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.run_mode    <= MODE_NONE;
      state_r.steps_left  <= '0;
      state_r.call_level  <= '0;
      state_r.inst_total  <= '0;
      state_r.load_total  <= '0;
      state_r.store_total <= '0;
    end else if (commit) begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/debug_step_run_controller.sv =====
`default_nettype none
// Debug run-control sequencer. Each input beat is one event (tuser: arm, trap or
// resume) and gives exactly one result beat: the stop / report / advance flags for
// a trap, the single-step / arm-breakpoints choice for a resume, and the
// instruction, load and store counters and the call depth after the event.
// An event is captured in a stage register, evaluated combinationally against
// the run state, and moved into the result register as the run state register
// is updated as well. One beat is taken every cycle while the result side keeps
// up, limited only by the single result register. Program the step mode and
// step budget registers on the cfg port while no event is in flight; they take
// effect at the next arm event.
module debug_step_run_controller
  import dsrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration writes
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [30:0]           cfg_wdata,
  // event stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [0] trap_is_breakpoint, [1] bkpt_hit, [2] bkpt_fires, [3] watch_hit,
  // [4] is_call, [5] is_return, [6] is_trap_return, [7] is_load, [8] is_store
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]            in_tuser,   // [1:0] op
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] stop, [1] report_breakpoint, [2] advance_pc, [3] single_step,
  // [4] arm_breakpoints, [36:5] instructions_seen, [68:37] loads_seen,
  // [100:69] stores_seen, [116:101] nesting
  output logic [OUT_DATA_W-1:0] out_tdata
);

  `include "debug_step_run_controller_assert.svh"

  logic [2:0]  step_mode_r;
  logic [30:0] step_budget_r;

  logic        stg_valid_r;
  dsrc_item_t  stg_item_r;
  logic        stg_adv;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  dsrc_state_t state_r;
  dsrc_state_t state_nxt;
  dsrc_flags_t flags;

  // Config registers: plain writes, no read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_mode_r   <= STEP_MODE_RST;
      step_budget_r <= STEP_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_STEP_MODE:  step_mode_r   <= cfg_wdata[2:0];
        REG_STEP_COUNT: step_budget_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage advances whenever the result register is free or being drained.
  assign stg_adv   = stg_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !stg_valid_r || stg_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_tready) begin
      stg_valid_r <= in_tvalid;
    end
  end

  // Capture the event payload on every accepted beat.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      stg_item_r.op                 <= in_tuser;
      stg_item_r.trap_is_breakpoint <= in_tdata[0];
      stg_item_r.bkpt_hit           <= in_tdata[1];
      stg_item_r.bkpt_fires         <= in_tdata[2];
      stg_item_r.watch_hit          <= in_tdata[3];
      stg_item_r.is_call            <= in_tdata[4];
      stg_item_r.is_return          <= in_tdata[5];
      stg_item_r.is_trap_return     <= in_tdata[6];
      stg_item_r.is_load            <= in_tdata[7];
      stg_item_r.is_store           <= in_tdata[8];
    end
  end

  dsrc_eval u_eval (
    .item        (stg_item_r),
    .cur         (state_r),
    .step_mode   (step_mode_r),
    .step_budget (step_budget_r),
    .nxt         (state_nxt),
    .flags       (flags)
  );

  dsrc_state_regs u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .commit    (stg_adv),
    .state_nxt (state_nxt),
    .state_r   (state_r)
  );

  // Result register: load on stage advance, drop when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stg_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_adv) begin
      out_data_r <= {3'b000,
                     state_nxt.call_level,
                     state_nxt.store_total,
                     state_nxt.load_total,
                     state_nxt.inst_total,
                     flags.arm_breakpoints,
                     flags.single_step,
                     flags.advance_pc,
                     flags.report_breakpoint,
                     flags.stop};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `DSRC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!out_tvalid && !stg_valid_r), "pipeline not empty after reset")
  `DSRC_ASSERT(a_state_hold, !stg_adv |=> $stable(state_r), "run state moved without an event")
  `DSRC_ASSERT(a_bkpt_keeps_mode, (stg_adv && flags.report_breakpoint) |=> (state_r.run_mode == $past(state_r.run_mode)), "breakpoint stop changed run mode")
  `DSRC_ASSERT(a_stop_clears_mode, (stg_adv && flags.stop && !flags.report_breakpoint) |=> (state_r.run_mode == MODE_NONE), "stop left run mode set")

endmodule
`default_nettype wire
